// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("%m");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// ===== rtl/core/tscc_pkg.sv =====
package tscc_pkg;
  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned MaxThresholds = 32;
  localparam int unsigned DistWidth = 16;
  localparam int unsigned AddrWidth = $clog2(MaxSamples);
  localparam int unsigned CntWidth = AddrWidth + 1;
  localparam int unsigned IdxWidth = 6;
  localparam int unsigned ThrWidth = $clog2(MaxThresholds);
  localparam int unsigned ProdWidth = DistWidth + IdxWidth;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoWindow = 2'd1;
  localparam logic [1:0] StatusEmptyClass = 2'd2;
  localparam logic [1:0] StatusDropped = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic                 clear;
    logic                 pos;
    logic [ProdWidth-1:0] lhs;
  } cell_tok_t;
endpackage

// ===== rtl/core/tscc_cell.sv =====
module tscc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tscc_pkg::cell_tok_t           tok_i,
  input  logic [tscc_pkg::ProdWidth-1:0] bound_i,
  output tscc_pkg::cell_tok_t           tok_o,
  output logic [tscc_pkg::CntWidth-1:0] pos_cnt_o,
  output logic [tscc_pkg::CntWidth-1:0] neg_cnt_o
);
  tscc_pkg::cell_tok_t tok_q;
  logic [tscc_pkg::CntWidth-1:0] pos_q, neg_q;
  logic hit;

  assign hit = tok_i.valid && (tok_i.lhs < bound_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      pos_q <= '0;
      neg_q <= '0;
    end else begin
      tok_q <= tok_i;
      if (tok_i.clear) begin
        pos_q <= '0;
        neg_q <= '0;
      end else if (hit) begin
        if (tok_i.pos) pos_q <= pos_q + 1'b1;
        else neg_q <= neg_q + 1'b1;
      end
    end
  end

  assign tok_o = tok_q;
  assign pos_cnt_o = pos_q;
  assign neg_cnt_o = neg_q;
endmodule

// ===== rtl/core/tscc_divider.sv =====
module tscc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] quo_q, quo_d, rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[31]} - {1'b0, den_i};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

// ===== rtl/core/threshold_sweep_confusion_counter_unit.sv =====
// Threshold sweep confusion counter. Samples load one per cycle while busy_o
// is low; a sample beyond 4096 held is dropped and flagged. The last sample
// starts the sweep: the stored samples stream through a chain of 32 threshold
// cells, one sample a cycle. Then one result per threshold is produced, each
// needing two serial divisions (threshold value and false-positive rate), and
// one more division gives the summary. Results appear for one cycle on
// result_valid_o and must be taken then; the block never waits on the receiver.
// busy_o stays high from the last sample until the summary result is presented
// and falls in that same cycle.
`include "assert_macros.svh"
module threshold_sweep_confusion_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] distance_i,
  input  logic        is_positive_i,
  input  logic        last_sample_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic [5:0]  threshold_index_o,
  output logic [15:0] threshold_value_o,
  output logic [12:0] true_pos_o,
  output logic [12:0] false_pos_o,
  output logic [12:0] true_neg_o,
  output logic [12:0] false_neg_o,
  output logic [15:0] err_at_recall_o,
  output logic        is_summary_o,
  output logic [1:0]  status_o,
  output logic        last_result_o
);
  localparam int unsigned AW = tscc_pkg::AddrWidth;
  localparam int unsigned CW = tscc_pkg::CntWidth;
  localparam int unsigned PW = tscc_pkg::ProdWidth;
  localparam int unsigned NT = tscc_pkg::MaxThresholds;
  localparam int unsigned TW = tscc_pkg::ThrWidth;

  typedef enum logic [3:0] {
    StLoad, StFeed, StDrain, StThrDiv, StThrWait, StFprDiv, StFprWait,
    StEmit, StSumDiv, StSumWait, StSum
  } state_e;

  state_e state_q;
  logic [5:0] nthr_q;

  logic [16:0] mem [tscc_pkg::MaxSamples];
  logic [16:0] rd_q;
  logic [CW-1:0] count_q, pos_tot_q, neg_tot_q, ptr_q;
  logic [15:0] max_q;
  logic ovf_q;
  logic [5:0] n_q, nm1;
  logic feed_v_q;
  logic [5:0] drain_q;
  logic [TW-1:0] idx_q;
  logic [21:0] rate_sum_q;
  logic [5:0] hits_q;
  logic [15:0] thr_val_q;

  logic rv_q, sum_q;
  logic [5:0] oidx_q;
  logic [15:0] oval_q, oerr_q;
  logic [12:0] tp_q, fp_q, tn_q, fn_q;
  logic [1:0] ost_q;

  logic accept, store_ok;
  assign accept = start_i && (state_q == StLoad);
  assign busy_o = (state_q != StLoad);
  assign store_ok = count_q < CW'(tscc_pkg::MaxSamples);

  always_ff @(posedge clk_i) begin
    if (accept && store_ok) mem[count_q[AW-1:0]] <= {is_positive_i, distance_i};
    rd_q <= mem[ptr_q[AW-1:0]];
  end

  // cell chain
  tscc_pkg::cell_tok_t tok [NT+1];
  logic [CW-1:0] pcnt [NT];
  logic [CW-1:0] ncnt [NT];
  logic [PW-1:0] bound [NT];
  logic [PW-1:0] lhs;
  assign lhs = PW'(rd_q[15:0]) * PW'(n_q - 6'd1);
  assign tok[0].valid = feed_v_q;
  assign tok[0].clear = (state_q == StLoad) && accept && last_sample_i;
  assign tok[0].pos = rd_q[16];
  assign tok[0].lhs = lhs;

  for (genvar g = 0; g < NT; g++) begin : g_cell
    assign bound[g] = (g < n_q) ? PW'(g) * PW'(max_q) : '0;
    tscc_cell u_cell (
      .clk_i, .rst_ni, .tok_i(tok[g]), .bound_i(bound[g]),
      .tok_o(tok[g+1]), .pos_cnt_o(pcnt[g]), .neg_cnt_o(ncnt[g])
    );
  end

  // shared divider
  logic div_start, div_done;
  logic [31:0] div_num, div_den, div_quo;
  tscc_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [CW-1:0] tp, fp;
  logic [CW+10-1:0] tp_k, p_lo, p_hi;
  logic in_win;
  assign tp = pcnt[idx_q];
  assign fp = ncnt[idx_q];
  assign tp_k = (CW+10)'(tp) * (CW+10)'(1000);
  assign p_lo = (CW+10)'(pos_tot_q) * (CW+10)'(949);
  assign p_hi = (CW+10)'(pos_tot_q) * (CW+10)'(951);
  assign in_win = (pos_tot_q != 0) && (neg_tot_q != 0) && (tp_k > p_lo) && (tp_k < p_hi);
  assign nm1 = n_q - 6'd1;

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = 32'd1;
    case (state_q)
      StThrDiv: begin
        div_start = 1'b1;
        div_num = 32'(idx_q) * 32'(max_q);
      end
      StFprDiv: begin
        div_start = 1'b1;
        div_num = {3'b0, fp, 16'b0};
      end
      StSumDiv: begin
        div_start = 1'b1;
        div_num = 32'(rate_sum_q);
      end
      default: ;
    endcase
    case (state_q)
      StThrDiv, StThrWait: div_den = 32'(nm1);
      StFprDiv, StFprWait: div_den = 32'(neg_tot_q);
      StSumDiv, StSumWait: div_den = 32'(hits_q);
      default: div_den = 32'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      nthr_q <= 6'd32;
      count_q <= '0;
      pos_tot_q <= '0;
      neg_tot_q <= '0;
      max_q <= '0;
      ovf_q <= 1'b0;
      ptr_q <= '0;
      feed_v_q <= 1'b0;
      drain_q <= '0;
      idx_q <= '0;
      rate_sum_q <= '0;
      hits_q <= '0;
      n_q <= 6'd2;
      thr_val_q <= '0;
      rv_q <= 1'b0;
      sum_q <= 1'b0;
      oidx_q <= '0;
      oval_q <= '0;
      tp_q <= '0;
      fp_q <= '0;
      tn_q <= '0;
      fn_q <= '0;
      oerr_q <= '0;
      ost_q <= tscc_pkg::StatusOk;
    end else begin
      rv_q <= (state_q == StEmit) || (state_q == StSum);
      if (cfg_we_i) nthr_q <= cfg_wdata_i;
      case (state_q)
        StLoad: begin
          if (accept) begin
            if (store_ok) begin
              count_q <= count_q + 1'b1;
              if (distance_i > max_q) max_q <= distance_i;
              if (is_positive_i) pos_tot_q <= pos_tot_q + 1'b1;
              else neg_tot_q <= neg_tot_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_sample_i) begin
              n_q <= (nthr_q < 6'd2) ? 6'd2 : ((nthr_q > 6'(NT)) ? 6'(NT) : nthr_q);
              ptr_q <= '0;
              state_q <= StFeed;
            end
          end
        end
        StFeed: begin
          if (ptr_q < count_q) begin
            ptr_q <= ptr_q + 1'b1;
            feed_v_q <= 1'b1;
          end else begin
            feed_v_q <= 1'b0;
            drain_q <= 6'(NT + 2);
            state_q <= StDrain;
          end
        end
        StDrain: begin
          feed_v_q <= 1'b0;
          drain_q <= drain_q - 6'd1;
          if (drain_q == 6'd0) begin
            idx_q <= '0;
            rate_sum_q <= '0;
            hits_q <= '0;
            state_q <= StThrDiv;
          end
        end
        StThrDiv: state_q <= StThrWait;
        StThrWait: if (div_done) begin
          thr_val_q <= div_quo[15:0];
          state_q <= StFprDiv;
        end
        StFprDiv: state_q <= StFprWait;
        StFprWait: if (div_done) begin
          if (in_win) begin
            rate_sum_q <= rate_sum_q + 22'((div_quo > 32'd65535) ? 32'd65535 : div_quo);
            hits_q <= hits_q + 6'd1;
          end
          state_q <= StEmit;
        end
        StEmit: begin
          sum_q <= 1'b0;
          oidx_q <= 6'(idx_q);
          oval_q <= thr_val_q;
          tp_q <= tp[12:0];
          fp_q <= fp[12:0];
          tn_q <= 13'(neg_tot_q - fp);
          fn_q <= 13'(pos_tot_q - tp);
          oerr_q <= '0;
          ost_q <= tscc_pkg::StatusOk;
          if (6'(idx_q) == nm1) state_q <= StSumDiv;
          else begin
            idx_q <= idx_q + 1'b1;
            state_q <= StThrDiv;
          end
        end
        StSumDiv: state_q <= StSumWait;
        StSumWait: if (div_done) state_q <= StSum;
        StSum: begin
          sum_q <= 1'b1;
          oidx_q <= '0;
          oval_q <= '0;
          tp_q <= '0;
          fp_q <= '0;
          tn_q <= '0;
          fn_q <= '0;
          if (pos_tot_q == 0 || neg_tot_q == 0) begin
            oerr_q <= '0;
            ost_q <= ovf_q ? tscc_pkg::StatusDropped : tscc_pkg::StatusEmptyClass;
          end else if (hits_q == 0) begin
            oerr_q <= '0;
            ost_q <= ovf_q ? tscc_pkg::StatusDropped : tscc_pkg::StatusNoWindow;
          end else begin
            oerr_q <= div_quo[15:0];
            ost_q <= ovf_q ? tscc_pkg::StatusDropped : tscc_pkg::StatusOk;
          end
          count_q <= '0;
          pos_tot_q <= '0;
          neg_tot_q <= '0;
          max_q <= '0;
          ovf_q <= 1'b0;
          state_q <= StLoad;
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign result_valid_o = rv_q;
  assign threshold_index_o = oidx_q;
  assign threshold_value_o = oval_q;
  assign true_pos_o = tp_q;
  assign false_pos_o = fp_q;
  assign true_neg_o = tn_q;
  assign false_neg_o = fn_q;
  assign err_at_recall_o = oerr_q;
  assign is_summary_o = sum_q;
  assign status_o = ost_q;
  assign last_result_o = sum_q;

  `ASSERT_NEVER(a_no_result_in_load, clk_i, rst_ni, rv_q && state_q == StLoad && !sum_q)
  `ASSERT_IMPL(a_sum_to_load, clk_i, rst_ni, (rv_q && sum_q) |-> state_q == StLoad)
  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CW'(tscc_pkg::MaxSamples))
endmodule

// ===== dv/tscc_checker.sv =====
module tscc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] distance_i,
  input  logic        is_positive_i,
  input  logic        last_sample_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        result_valid_i,
  input  logic [5:0]  threshold_index_i,
  input  logic [15:0] threshold_value_i,
  input  logic [12:0] true_pos_i,
  input  logic [12:0] false_pos_i,
  input  logic [12:0] true_neg_i,
  input  logic [12:0] false_neg_i,
  input  logic [15:0] err_at_recall_i,
  input  logic        is_summary_i,
  input  logic [1:0]  status_i,
  input  logic        last_result_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  index;
    logic [15:0] value;
    logic [12:0] tp;
    logic [12:0] fp;
    logic [12:0] tn;
    logic [12:0] fn;
    logic [15:0] err;
    logic        summary;
    logic [1:0]  status;
    logic        last;
  } sweep_result_t;

  sweep_result_t   sweep_q[$];
  logic [15:0]     dist_mem[tscc_pkg::MaxSamples];
  logic            pos_mem[tscc_pkg::MaxSamples];
  int unsigned     held;
  logic [15:0]     max_dist;
  int unsigned     pos_total;
  int unsigned     neg_total;
  logic            dropped;
  logic [5:0]      thr_reg;

  assign pending_o = sweep_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic predict_sweep();
    int unsigned     n;
    longint unsigned tp, fp, p, q, r, rate_sum, hits, lhs;
    sweep_result_t   res;
    logic [1:0]      st;
    n = 32'(thr_reg);
    if (n < 2) n = 2;
    if (n > tscc_pkg::MaxThresholds) n = tscc_pkg::MaxThresholds;
    p = 64'(pos_total);
    q = 64'(neg_total);
    rate_sum = 0;
    hits = 0;
    for (int unsigned i = 0; i < n; i++) begin
      tp = 0;
      fp = 0;
      for (int unsigned s = 0; s < held; s++) begin
        lhs = longint'(dist_mem[s]) * (n - 1);
        if (lhs < longint'(i) * max_dist) begin
          if (pos_mem[s]) tp++;
          else fp++;
        end
      end
      res = '0;
      res.index = 6'(i);
      res.value = 16'((longint'(i) * max_dist) / (n - 1));
      res.tp = 13'(tp);
      res.fp = 13'(fp);
      res.tn = 13'(q - fp);
      res.fn = 13'(p - tp);
      sweep_q = {sweep_q, res};
      if (p != 0 && q != 0 && tp * 1000 > p * 949 && tp * 1000 < p * 951) begin
        r = (fp << 16) / q;
        if (r > 65535) r = 65535;
        rate_sum += r;
        hits++;
      end
    end
    res = '0;
    if (p == 0 || q == 0) st = tscc_pkg::StatusEmptyClass;
    else if (hits == 0) st = tscc_pkg::StatusNoWindow;
    else begin
      st = tscc_pkg::StatusOk;
      res.err = 16'(rate_sum / hits);
    end
    if (dropped) st = tscc_pkg::StatusDropped;
    res.summary = 1'b1;
    res.status = st;
    res.last = 1'b1;
    sweep_q = {sweep_q, res};
    held = 0;
    max_dist = '0;
    pos_total = 0;
    neg_total = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sweep_result_t want;
    if (!rst_ni) begin
      thr_reg <= 6'd32;
      held = 0;
      max_dist = '0;
      pos_total = 0;
      neg_total = 0;
      dropped = 1'b0;
      errors_o = 0;
      results_o = 0;
    end else begin
      if (result_valid_i) begin
        results_o++;
        if (sweep_q.size() == 0) begin
          report("result with nothing expected, index", threshold_index_i, 0);
        end else begin
          want = sweep_q.pop_front();
          if (threshold_index_i !== want.index) report("threshold_index", threshold_index_i, want.index);
          if (threshold_value_i !== want.value) report("threshold_value", threshold_value_i, want.value);
          if (true_pos_i !== want.tp) report("true_pos", true_pos_i, want.tp);
          if (false_pos_i !== want.fp) report("false_pos", false_pos_i, want.fp);
          if (true_neg_i !== want.tn) report("true_neg", true_neg_i, want.tn);
          if (false_neg_i !== want.fn) report("false_neg", false_neg_i, want.fn);
          if (err_at_recall_i !== want.err) report("err_at_recall", err_at_recall_i, want.err);
          if (is_summary_i !== want.summary) report("is_summary", is_summary_i, want.summary);
          if (status_i !== want.status) report("status", status_i, want.status);
          if (last_result_i !== want.last) report("last_result", last_result_i, want.last);
        end
      end
      if (start_i && !busy_i) begin
        if (held < tscc_pkg::MaxSamples) begin
          dist_mem[held] = distance_i;
          pos_mem[held] = is_positive_i;
          held++;
          if (distance_i > max_dist) max_dist = distance_i;
          if (is_positive_i) pos_total++;
          else neg_total++;
        end else begin
          dropped = 1'b1;
        end
        if (last_sample_i) predict_sweep();
      end
      if (cfg_we_i) thr_reg <= cfg_wdata_i;
    end
  end
endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] distance_i = '0;
  logic        is_positive_i = 1'b0;
  logic        last_sample_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [5:0]  threshold_index_o;
  logic [15:0] threshold_value_o;
  logic [12:0] true_pos_o, false_pos_o, true_neg_o, false_neg_o;
  logic [15:0] err_at_recall_o;
  logic        is_summary_o;
  logic [1:0]  status_o;
  logic        last_result_o;
  int          errors, pending, results;
  int          idle_cycles = 0;
  int          samples_sent = 0;
  int          runs_done = 0;
  bit          no_gaps = 1'b0;

  always #5ns clk_i = ~clk_i;

  threshold_sweep_confusion_counter_unit u_dut (.*);

  tscc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .distance_i, .is_positive_i,
    .last_sample_i, .cfg_we_i, .cfg_wdata_i, .result_valid_i(result_valid_o),
    .threshold_index_i(threshold_index_o), .threshold_value_i(threshold_value_o),
    .true_pos_i(true_pos_o), .false_pos_i(false_pos_o), .true_neg_i(true_neg_o),
    .false_neg_i(false_neg_o), .err_at_recall_i(err_at_recall_o),
    .is_summary_i(is_summary_o), .status_i(status_o), .last_result_i(last_result_o),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d results pending", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic gap();
    int n;
    if (no_gaps) return;
    n = $urandom_range(0, 99);
    if (n < 60) return;
    start_i <= 1'b0;
    if (n < 92) repeat ($urandom_range(1, 3)) @(posedge clk_i);
    else repeat ($urandom_range(10, 60)) @(posedge clk_i);
  endtask

  task automatic send(input logic [15:0] d, input logic p, input logic l);
    start_i <= 1'b1;
    distance_i <= d;
    is_positive_i <= p;
    last_sample_i <= l;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    runs_done++;
  endtask

  task automatic set_thresholds(input logic [5:0] n);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // positives spread so that some threshold lands near 95% recall
  task automatic recall_run(input int npos, input int nneg, input int scale);
    int total, k, pi;
    total = npos + nneg;
    pi = 0;
    for (k = 0; k < total; k++) begin
      gap();
      if (pi < npos && ($urandom_range(0, total - 1) < npos || k - pi >= nneg)) begin
        send(16'($urandom_range(0, scale)), 1'b1, k == total - 1);
        pi++;
      end else begin
        send(16'($urandom_range(0, 65535)), 1'b0, k == total - 1);
      end
    end
    drain();
  endtask

  task automatic noise_run(input int len);
    for (int k = 0; k < len; k++) begin
      gap();
      send(16'($urandom()), 1'($urandom_range(0, 1)), k == len - 1);
    end
    drain();
  endtask

  initial begin
    logic [5:0] cfg;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone last sample, empty negative class
    send(16'hFFFF, 1'b1, 1'b1);
    drain();
    // all distances zero, empty positive class
    send(16'h0000, 1'b0, 1'b0);
    send(16'h0000, 1'b0, 1'b1);
    drain();
    // twenty positives on a ramp, one far negative: no window hit expected
    for (int k = 0; k < 20; k++) send(16'(k * 1000), 1'b1, 1'b0);
    send(16'hFFFF, 1'b0, 1'b1);
    drain();

    set_thresholds(6'd2);
    send(16'h5555, 1'b1, 1'b0);
    send(16'hAAAA, 1'b0, 1'b1);
    drain();
    set_thresholds(6'd0);
    noise_run(4);
    set_thresholds(6'd1);
    noise_run(4);
    set_thresholds(6'd63);
    noise_run(5);
    set_thresholds(6'd33);
    recall_run(20, 3, 20000);

    while (samples_sent < 260) begin
      case ($urandom_range(0, 5))
        0: cfg = 6'd32;
        1: cfg = 6'd2;
        2: cfg = 6'd63;
        default: cfg = 6'($urandom_range(0, 63));
      endcase
      set_thresholds(cfg);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0)
        recall_run($urandom_range(0, 1) ? 20 : 40, $urandom_range(1, 8),
                   $urandom_range(500, 65535));
      else noise_run($urandom_range(1, 12));
    end

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d sweeps over %0d samples, %0d results checked,", runs_done,
             samples_sent, results);
    $display("covering clamped and extreme threshold counts, empty classes and recall hits");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
